>>> sv/pph_pkg.sv
package pph_pkg;

  localparam int COORD_WIDTH = 24;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLICK_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL_SQ   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED   = 3'd3;

  // multiplications of one segment test
  typedef enum logic [3:0] {
    OP_DXDX   = 4'd0,
    OP_DYDY   = 4'd1,
    OP_DXPX   = 4'd2,
    OP_DYPY   = 4'd3,
    OP_DXPY   = 4'd4,
    OP_DYPX   = 4'd5,
    OP_CRCR   = 4'd6,
    OP_TOLLEN = 4'd7,
    OP_QXQX   = 4'd8,
    OP_QYQY   = 4'd9,
    OP_PXPX   = 4'd10,
    OP_PYPY   = 4'd11
  } op_e;

  typedef struct packed {
    logic load;       // take a new vertex, segment prev to current
    logic new_poly;   // vertex opens a polyline
    logic first_seg;  // set up the segment first to current
    logic mul_start;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic len_zero;
    logic in_box;
    logic cr_lt;
    logic e_lt;
    logic closed;
  } status_t;

endpackage

>>> sv/pph_mul.sv
module pph_mul #(
  parameter int OW = 52
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [OW-1:0] a_i,
  input  logic signed [OW-1:0] b_i,
  output logic                 done_o,
  output logic signed [2*OW-1:0] p_o
);

  localparam int CntW = $clog2(OW);

  logic            busy_q, fin_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [OW-1:0]   ma_q, hi_q, lo_q;
  logic            neg_q;
  logic [2*OW-1:0] p_q;

  logic [OW-1:0]   a_mag, b_mag;
  logic [OW:0]     sum;
  logic [2*OW-1:0] full;

  assign a_mag = a_i[OW-1] ? (~a_i) + {{(OW-1){1'b0}}, 1'b1} : a_i;
  assign b_mag = b_i[OW-1] ? (~b_i) + {{(OW-1){1'b0}}, 1'b1} : b_i;
  assign sum   = {1'b0, hi_q} + {1'b0, (lo_q[0] ? ma_q : {OW{1'b0}})};
  assign full  = {hi_q, lo_q};

  // one multiplier bit per cycle, magnitudes, sign applied at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(OW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ma_q  <= a_mag;
      lo_q  <= b_mag;
      hi_q  <= '0;
      neg_q <= a_i[OW-1] ^ b_i[OW-1];
    end else if (busy_q) begin
      hi_q <= sum[OW:1];
      lo_q <= {sum[0], lo_q[OW-1:1]};
    end
    if (fin_q) begin
      p_q <= neg_q ? (~full) + {{(2*OW-1){1'b0}}, 1'b1} : full;
    end
  end

  assign done_o = done_q;
  assign p_o    = $signed(p_q);

endmodule

>>> sv/pph_dpath.sv
module pph_dpath #(
  parameter int CW = 24,
  parameter int TolW = 51
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [pph_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TolW-1:0]               cfg_data_i,
  input  logic signed [CW-1:0]          vertex_x_i,
  input  logic signed [CW-1:0]          vertex_y_i,
  input  pph_pkg::cmd_t                 cmd_i,
  output pph_pkg::status_t              status_o
);

  localparam int OW = 2 * CW + 4;
  localparam int PW = 2 * OW;

  logic signed [CW-1:0] click_x_q, click_y_q;
  logic [TolW-1:0]      tol_q;
  logic                 closed_q;

  logic signed [CW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, cur_x_q, cur_y_q;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;

  logic signed [OW-1:0] len2_q, dot_q, cr_q, e_q;
  logic signed [PW-1:0] lhs_q, tlen_q;
  pph_pkg::op_e         op_q;

  logic signed [CW:0]   dx, dy, px, py, qx, qy;
  logic signed [OW-1:0] tol_ext, opa, opb, p_lo;
  logic signed [PW-1:0] p;
  logic                 mul_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      click_x_q <= '0;
      click_y_q <= '0;
      tol_q     <= '0;
      closed_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pph_pkg::CFG_CLICK_X: click_x_q <= $signed(cfg_data_i[CW-1:0]);
        pph_pkg::CFG_CLICK_Y: click_y_q <= $signed(cfg_data_i[CW-1:0]);
        pph_pkg::CFG_TOL_SQ:  tol_q     <= cfg_data_i;
        pph_pkg::CFG_CLOSED:  closed_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
    end else if (cmd_i.load) begin
      prev_x_q <= vertex_x_i;
      prev_y_q <= vertex_y_i;
      if (cmd_i.new_poly) begin
        first_x_q <= vertex_x_i;
        first_y_q <= vertex_y_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= vertex_x_i;
      cur_y_q <= vertex_y_i;
      ax_q    <= prev_x_q;
      ay_q    <= prev_y_q;
      bx_q    <= vertex_x_i;
      by_q    <= vertex_y_i;
    end else if (cmd_i.first_seg) begin
      ax_q <= first_x_q;
      ay_q <= first_y_q;
      bx_q <= cur_x_q;
      by_q <= cur_y_q;
    end
    if (cmd_i.mul_start) begin
      op_q <= cmd_i.op;
    end
    if (mul_done) begin
      case (op_q)
        pph_pkg::OP_DXDX:   len2_q <= p_lo;
        pph_pkg::OP_DYDY:   len2_q <= len2_q + p_lo;
        pph_pkg::OP_DXPX:   dot_q  <= p_lo;
        pph_pkg::OP_DYPY:   dot_q  <= dot_q + p_lo;
        pph_pkg::OP_DXPY:   cr_q   <= p_lo;
        pph_pkg::OP_DYPX:   cr_q   <= cr_q - p_lo;
        pph_pkg::OP_CRCR:   lhs_q  <= p;
        pph_pkg::OP_TOLLEN: tlen_q <= p;
        pph_pkg::OP_QXQX:   e_q    <= p_lo;
        pph_pkg::OP_QYQY:   e_q    <= e_q + p_lo;
        pph_pkg::OP_PXPX:   e_q    <= p_lo;
        pph_pkg::OP_PYPY:   e_q    <= e_q + p_lo;
        default: ;
      endcase
    end
  end

  assign dx = {bx_q[CW-1], bx_q} - {ax_q[CW-1], ax_q};
  assign dy = {by_q[CW-1], by_q} - {ay_q[CW-1], ay_q};
  assign px = {click_x_q[CW-1], click_x_q} - {ax_q[CW-1], ax_q};
  assign py = {click_y_q[CW-1], click_y_q} - {ay_q[CW-1], ay_q};
  assign qx = {click_x_q[CW-1], click_x_q} - {bx_q[CW-1], bx_q};
  assign qy = {click_y_q[CW-1], click_y_q} - {by_q[CW-1], by_q};
  assign tol_ext = $signed({{(OW-TolW){1'b0}}, tol_q});
  assign p_lo = p[OW-1:0];

  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd_i.op)
      pph_pkg::OP_DXDX: begin
        opa = {{(OW-CW-1){dx[CW]}}, dx};
        opb = {{(OW-CW-1){dx[CW]}}, dx};
      end
      pph_pkg::OP_DYDY: begin
        opa = {{(OW-CW-1){dy[CW]}}, dy};
        opb = {{(OW-CW-1){dy[CW]}}, dy};
      end
      pph_pkg::OP_DXPX: begin
        opa = {{(OW-CW-1){dx[CW]}}, dx};
        opb = {{(OW-CW-1){px[CW]}}, px};
      end
      pph_pkg::OP_DYPY: begin
        opa = {{(OW-CW-1){dy[CW]}}, dy};
        opb = {{(OW-CW-1){py[CW]}}, py};
      end
      pph_pkg::OP_DXPY: begin
        opa = {{(OW-CW-1){dx[CW]}}, dx};
        opb = {{(OW-CW-1){py[CW]}}, py};
      end
      pph_pkg::OP_DYPX: begin
        opa = {{(OW-CW-1){dy[CW]}}, dy};
        opb = {{(OW-CW-1){px[CW]}}, px};
      end
      pph_pkg::OP_CRCR: begin
        opa = cr_q;
        opb = cr_q;
      end
      pph_pkg::OP_TOLLEN: begin
        opa = tol_ext;
        opb = len2_q;
      end
      pph_pkg::OP_QXQX: begin
        opa = {{(OW-CW-1){qx[CW]}}, qx};
        opb = {{(OW-CW-1){qx[CW]}}, qx};
      end
      pph_pkg::OP_QYQY: begin
        opa = {{(OW-CW-1){qy[CW]}}, qy};
        opb = {{(OW-CW-1){qy[CW]}}, qy};
      end
      pph_pkg::OP_PXPX: begin
        opa = {{(OW-CW-1){px[CW]}}, px};
        opb = {{(OW-CW-1){px[CW]}}, px};
      end
      pph_pkg::OP_PYPY: begin
        opa = {{(OW-CW-1){py[CW]}}, py};
        opb = {{(OW-CW-1){py[CW]}}, py};
      end
      default: ;
    endcase
  end

  pph_mul #(.OW(OW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (mul_done),
    .p_o     (p)
  );

  assign status_o.mul_done = mul_done;
  assign status_o.len_zero = (len2_q == '0);
  assign status_o.in_box   = !dot_q[OW-1] && (dot_q <= len2_q);
  assign status_o.cr_lt    = lhs_q < tlen_q;
  assign status_o.e_lt     = e_q < tol_ext;
  assign status_o.closed   = closed_q;

endmodule

>>> sv/pph_ctrl.sv
module pph_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             last_vertex_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             hit_o,
  input  pph_pkg::status_t status_i,
  output pph_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SEG2   = 6'b000010,
    S_START  = 6'b000100,
    S_WAIT   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  pph_pkg::op_e op_q, op_d;
  logic         have_prev_q, have_prev_d;
  logic         hit_q, hit_d;
  logic         last_q, last_d;
  logic         seg2_q, seg2_d;

  always_comb begin
    logic fin, fin_hit;
    fin         = 1'b0;
    fin_hit     = 1'b0;
    state_d     = state_q;
    op_d        = op_q;
    have_prev_d = have_prev_q;
    hit_d       = hit_q;
    last_d      = last_q;
    seg2_d      = seg2_q;
    cmd_o       = '0;
    cmd_o.op    = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.new_poly = !have_prev_q;
          have_prev_d    = !last_vertex_i;
          last_d         = last_vertex_i;
          hit_d          = have_prev_q ? hit_q : 1'b0;
          seg2_d         = last_vertex_i && status_i.closed;
          if (have_prev_q) begin
            op_d    = pph_pkg::OP_DXDX;
            state_d = S_START;
          end else if (last_vertex_i && status_i.closed) begin
            state_d = S_SEG2;
          end else if (last_vertex_i) begin
            state_d = S_OUT;
          end
        end
      end
      S_SEG2: begin
        cmd_o.first_seg = 1'b1;
        seg2_d          = 1'b0;
        op_d            = pph_pkg::OP_DXDX;
        state_d         = S_START;
      end
      S_START: begin
        cmd_o.mul_start = 1'b1;
        state_d         = S_WAIT;
      end
      S_WAIT: begin
        if (status_i.mul_done) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        state_d = S_START;
        case (op_q)
          pph_pkg::OP_DXDX: op_d = pph_pkg::OP_DYDY;
          pph_pkg::OP_DYDY: op_d = status_i.len_zero ? pph_pkg::OP_QXQX : pph_pkg::OP_DXPX;
          pph_pkg::OP_DXPX: op_d = pph_pkg::OP_DYPY;
          pph_pkg::OP_DYPY: op_d = status_i.in_box ? pph_pkg::OP_DXPY : pph_pkg::OP_QXQX;
          pph_pkg::OP_DXPY: op_d = pph_pkg::OP_DYPX;
          pph_pkg::OP_DYPX: op_d = pph_pkg::OP_CRCR;
          pph_pkg::OP_CRCR: op_d = pph_pkg::OP_TOLLEN;
          pph_pkg::OP_TOLLEN: begin
            fin     = 1'b1;
            fin_hit = status_i.cr_lt;
          end
          pph_pkg::OP_QXQX: op_d = pph_pkg::OP_QYQY;
          pph_pkg::OP_QYQY: begin
            if (status_i.e_lt) begin
              fin     = 1'b1;
              fin_hit = 1'b1;
            end else begin
              op_d = pph_pkg::OP_PXPX;
            end
          end
          pph_pkg::OP_PXPX: op_d = pph_pkg::OP_PYPY;
          pph_pkg::OP_PYPY: begin
            fin     = 1'b1;
            fin_hit = status_i.e_lt;
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          hit_d = hit_q | fin_hit;
          if (seg2_q) state_d = S_SEG2;
          else if (last_q) state_d = S_OUT;
          else state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          hit_d   = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= pph_pkg::OP_DXDX;
      have_prev_q <= 1'b0;
      hit_q       <= 1'b0;
      last_q      <= 1'b0;
      seg2_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      have_prev_q <= have_prev_d;
      hit_q       <= hit_d;
      last_q      <= last_d;
      seg2_q      <= seg2_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign hit_o       = hit_q;

`ifndef NO_ASSERTIONS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input and output open together");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.mul_done |-> (state_q == S_WAIT))
    else $error("multiplier finished outside wait");
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && have_prev_q) |=> !in_ready_o)
    else $error("ready while a segment is pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(hit_o)))
    else $error("result changed while stalled");
`endif

endmodule

>>> sv/polyline_proximity_hit_test.sv
// Polyline proximity hit test. Vertices stream in one item at a time; each
// segment from the previous vertex to the current one is tested exactly
// against the configured click point and squared tolerance, and one hit item
// comes out at the vertex marked last (closed mode also tests first to last).
// All products run through one shared shift-add multiplier that retires one
// bit per cycle. A segment needs 4 to 8 multiplications; the first vertex needs
// none, and a closed last vertex up to twice the work of another vertex.
// Configuration writes are taken at once.
module polyline_proximity_hit_test #(
  parameter int COORD_WIDTH = pph_pkg::COORD_WIDTH,
  parameter int TOL_WIDTH = (2 * COORD_WIDTH + 3 > 64) ? 64 : 2 * COORD_WIDTH + 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pph_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [TOL_WIDTH-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] vertex_x_i,
  input  logic signed [COORD_WIDTH-1:0] vertex_y_i,
  input  logic                          last_vertex_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          hit_o
);

  pph_pkg::cmd_t    cmd;
  pph_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  pph_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .last_vertex_i (last_vertex_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .hit_o         (hit_o),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  pph_dpath #(.CW(COORD_WIDTH), .TolW(TOL_WIDTH)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .vertex_x_i  (vertex_x_i),
    .vertex_y_i  (vertex_y_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

>>> sim/polyline_proximity_hit_test_tb.sv
`timescale 1ns / 1ps

class polyline_hit_predictor;
  typedef logic signed [127:0] wide_t;

  logic signed [23:0] click_x, click_y;
  logic [50:0]        tol_sq;
  bit                 closed;
  logic signed [23:0] first_x, first_y, prev_x, prev_y;
  bit                 have_prev, hit_acc;
  bit                 expected_hits[$];
  int                 n_errors, n_results, n_hits;

  function new();
    click_x = '0; click_y = '0; tol_sq = '0; closed = 0;
    first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
    have_prev = 0; hit_acc = 0;
    n_errors = 0; n_results = 0; n_hits = 0;
  endfunction

  function void write_reg(logic [pph_pkg::CFG_IDX_W-1:0] idx, logic [50:0] data);
    case (idx)
      pph_pkg::CFG_CLICK_X: click_x = data[23:0];
      pph_pkg::CFG_CLICK_Y: click_y = data[23:0];
      pph_pkg::CFG_TOL_SQ:  tol_sq = data;
      pph_pkg::CFG_CLOSED:  closed = data[0];
      default: ;
    endcase
  endfunction

  function bit seg_near(logic signed [23:0] ax_in, ay_in, bx_in, by_in);
    wide_t ax, ay, bx, by, cx, cy, tol, dx, dy, px, py, qx, qy, len2, dot, cr;
    ax = ax_in; ay = ay_in; bx = bx_in; by = by_in;
    cx = click_x; cy = click_y; tol = tol_sq;
    dx = bx - ax; dy = by - ay;
    px = cx - ax; py = cy - ay;
    qx = cx - bx; qy = cy - by;
    len2 = dx * dx + dy * dy;
    if (len2 != 0) begin
      dot = dx * px + dy * py;
      if (dot >= 0 && dot <= len2) begin
        cr = dx * py - dy * px;
        return (cr * cr) < (tol * len2);
      end
    end
    // foot outside the segment or no segment at all: nearest endpoint decides
    if (qx * qx + qy * qy < tol) return 1;
    return (px * px + py * py) < tol;
  endfunction

  function void note_vertex(logic signed [23:0] vx, vy, bit last);
    bit h;
    if (!have_prev) begin
      first_x = vx; first_y = vy;
      hit_acc = 0;
      have_prev = 1;
    end else if (seg_near(prev_x, prev_y, vx, vy)) begin
      hit_acc = 1;
    end
    prev_x = vx; prev_y = vy;
    if (last) begin
      h = hit_acc;
      if (closed && seg_near(first_x, first_y, vx, vy)) h = 1;
      expected_hits.insert(expected_hits.size(), h);
      have_prev = 0;
      hit_acc = 0;
    end
  endfunction

  function void check_hit(bit got);
    bit want;
    n_results++;
    if (got) n_hits++;
    if (expected_hits.size() == 0) begin
      $display("%0t: unexpected hit item, expected none, got %0b", $time, got);
      n_errors++;
      return;
    end
    want = expected_hits.pop_front();
    if (want !== got) begin
      $display("%0t: hit mismatch, expected %0b, got %0b", $time, want, got);
      n_errors++;
    end
  endfunction
endclass

module polyline_proximity_hit_test_tb;

  localparam int SETTLE_CYCLES = 1200;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [pph_pkg::CFG_IDX_W-1:0]   cfg_index_i;
  logic [50:0]                     cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic signed [23:0]              vertex_x_i;
  logic signed [23:0]              vertex_y_i;
  logic                            last_vertex_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            hit_o;

  polyline_proximity_hit_test u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .vertex_x_i, .vertex_y_i, .last_vertex_i,
    .out_valid_o, .out_ready_i, .hit_o
  );

  polyline_hit_predictor pred = new();

  bit steady;     // no idling on either side
  bit hold_req;   // receiver holds off for a long stretch
  int n_items;
  int n_cfg;
  logic signed [23:0] last_x, last_y;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  // receiver side
  initial begin
    int hold;
    out_ready_i = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        out_ready_i = 0;
        hold = 3000;
        while (hold > 0) begin
          @(negedge clk_i);
          hold--;
        end
      end else if (!steady && $urandom_range(0, 9) < 3) begin
        out_ready_i = 0;
        repeat (gap_len() - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) pred.check_hit(hit_o);
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_vertex(logic signed [23:0] x, y, bit last);
    in_valid_i = 1;
    vertex_x_i = x;
    vertex_y_i = y;
    last_vertex_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    pred.note_vertex(x, y, last);
    n_items++;
    last_x = x; last_y = y;
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 9) < 3) begin
      in_valid_i = 0;
      repeat (gap_len() - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [pph_pkg::CFG_IDX_W-1:0] idx, logic [50:0] data);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    pred.write_reg(idx, data);
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  // block idle: every hit item in and any trailing segment work finished
  task automatic drain();
    in_valid_i = 0;
    while (pred.expected_hits.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic signed [23:0] near_coord(logic signed [23:0] c);
    int sh;
    int off;
    if ($urandom_range(0, 9) < 3) return 24'($urandom);
    sh = $urandom_range(2, 13);
    off = int'($urandom_range(0, 2 << sh)) - (1 << sh);
    return 24'(c + off);
  endfunction

  task automatic send_polyline();
    int len;
    logic signed [23:0] x, y;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 9) == 0) begin
        x = last_x; y = last_y;   // degenerate segment
      end else begin
        x = near_coord(pred.click_x);
        y = near_coord(pred.click_y);
      end
      send_vertex(x, y, i == len - 1);
    end
  endtask

  initial begin
    logic [50:0] tol;
    int r;
    steady = 0; hold_req = 0; n_items = 0; n_cfg = 0;
    last_x = '0; last_y = '0;
    rst_ni = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 0; vertex_x_i = '0; vertex_y_i = '0; last_vertex_i = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: click at (1.0, 0), radius 1.0
    write_reg(pph_pkg::CFG_CLICK_X, 51'h100);
    write_reg(pph_pkg::CFG_CLICK_Y, 51'h0);
    write_reg(pph_pkg::CFG_TOL_SQ, 51'h10000);
    write_reg(pph_pkg::CFG_CLOSED, 51'h0);
    send_vertex(24'sh0, 24'sh0, 1);                  // single vertex, open
    send_vertex(-24'sd1000, 24'sh0, 0);
    send_vertex(24'sd1000, 24'sh0, 1);               // passes through click
    send_vertex(24'sd5, 24'sd5, 0);
    send_vertex(24'sd5, 24'sd5, 1);                  // degenerate
    send_vertex(24'sh7fffff, 24'sh7fffff, 0);
    send_vertex(-24'sh800000, -24'sh800000, 1);      // full diagonal
    send_vertex(-24'sh800000, 24'sh7fffff, 0);
    send_vertex(24'sh7fffff, -24'sh800000, 0);
    send_vertex(24'sh300, 24'sh0, 1);                // foot outside segment
    send_vertex(24'sh100, 24'sh100, 0);
    send_vertex(24'sh100, 24'sh0ff, 1);              // endpoint just inside
    drain();
    write_reg(pph_pkg::CFG_CLOSED, 51'h1);
    write_reg(3'd5, 51'h7_ffff_ffff_ffff);           // no such register
    send_vertex(24'sh100, 24'sh0, 1);                // single vertex, closed
    send_vertex(24'sh0, 24'sh0, 0);
    send_vertex(24'sh200, 24'sh0, 1);                // two vertices, closed
    send_vertex(24'sh0, 24'sh1000, 0);
    send_vertex(24'sh1000, 24'sh1000, 0);
    send_vertex(24'sh1000, -24'sh1000, 0);
    send_vertex(24'sh0, -24'sh1000, 1);              // closing edge exactly at tolerance, no hit
    drain();

    for (int p = 0; p < 8; p++) begin
      steady = (p == 2);
      case (p)
        1: begin
          // upper bits dropped
          write_reg(pph_pkg::CFG_CLICK_X, {27'h7ffffff, 24'h7fffff});
          write_reg(pph_pkg::CFG_CLICK_Y, 51'h7fffff);
        end
        2: begin
          write_reg(pph_pkg::CFG_CLICK_X, 51'h800000);
          write_reg(pph_pkg::CFG_CLICK_Y, 51'h800000);
        end
        default: begin
          write_reg(pph_pkg::CFG_CLICK_X, 51'({$urandom, $urandom}));
          write_reg(pph_pkg::CFG_CLICK_Y, 51'({$urandom, $urandom}));
        end
      endcase
      r = $urandom_range(1, 4096);
      tol = 51'(r * r);
      if (p == 3) tol = '0;
      if (p == 4) tol = '1;
      if (p == 7) tol = 51'({$urandom, $urandom});
      write_reg(pph_pkg::CFG_TOL_SQ, tol);
      write_reg(pph_pkg::CFG_CLOSED,
                51'({$urandom, $urandom}) & 51'h7_ffff_ffff_fffe | 51'(p % 2));
      write_reg(pph_pkg::CFG_IDX_W'($urandom_range(4, 7)), 51'({$urandom, $urandom}));

      if (p == 5) hold_req = 1;
      while (n_items < 21 + (p + 1) * 75) begin
        send_polyline();
        if (p == 6 && $urandom_range(0, 19) == 0) begin
          // sender waits for every hit item before going on
          in_valid_i = 0;
          while (pred.expected_hits.size() != 0) @(negedge clk_i);
        end
      end
      drain();
    end

    $display("covered %0d vertices, %0d register writes, %0d hit items (%0d hits)",
             n_items, n_cfg, pred.n_results, pred.n_hits);
    if (pred.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pph_pkg.sv
sv/pph_mul.sv
sv/pph_dpath.sv
sv/pph_ctrl.sv
sv/polyline_proximity_hit_test.sv
sim/polyline_proximity_hit_test_tb.sv
